// ----- src/fl4_pkg.sv -----
package fl4_pkg;

	localparam int unsigned LANES  = 4;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned SUM_W  = 64;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SUM_W-1:0]  sum_t;

	// running sums of one lane
	typedef struct packed {
		sum_t a;
		sum_t b;
		sum_t c;
		sum_t d;
	} lane_sums_t;

endpackage

// ----- src/fl4_lane.sv -----
// One lane of the four-lane Fletcher-4 sum: a += w, b += a, c += b, d += c.
module fl4_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                clr,
	input  fl4_pkg::word_t      word,
	output fl4_pkg::lane_sums_t sums_next,
	output fl4_pkg::lane_sums_t sums
);

	fl4_pkg::lane_sums_t sums_q;
	fl4_pkg::sum_t       w_ext;

	assign w_ext = {{(fl4_pkg::SUM_W - fl4_pkg::WORD_W){1'b0}}, word};

	// flattened chain, each sum is a short multi-operand add
	always_comb begin
		sums_next.a = sums_q.a + w_ext;
		sums_next.b = sums_q.b + sums_q.a + w_ext;
		sums_next.c = sums_q.c + sums_q.b + sums_q.a + w_ext;
		sums_next.d = sums_q.d + sums_q.c + sums_q.b + sums_q.a + w_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (en) begin
			if (clr) begin
				sums_q <= '0;
			end else begin
				sums_q <= sums_next;
			end
		end
	end

	assign sums = sums_q;

endmodule

// ----- src/fletcher4_four_lane_checksum.sv -----
// Four-lane Fletcher-4 checksum, 64-bit sums. Each input beat carries four
// 32-bit words (optionally byte-swapped per word by byte_swap); word i feeds
// lane i, which keeps running sums a, b, c, d modulo 2^64. A beat with tlast
// set is summed, then the sixteen lane sums are merged into the four
// Fletcher-4 words and sent as one output beat, and the lanes start afresh.
// Beats without tlast give no output. Rate: one beat per clock, limited by
// the lane add in each lane. A tlast beat waits only while all three merge
// stages hold results behind a stalled output; plain beats keep flowing
// then. The checksum of a tlast beat passes the input register, the snapshot,
// the merge partials and the output register, in that order.
module fletcher4_four_lane_checksum (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: byte_swap register
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // word_zero, word_one, word_two, word_three
	input  logic         s_tlast,   // last
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata    // sum_a, sum_b, sum_c, sum_d
);

	localparam int unsigned LN = fl4_pkg::LANES;
	localparam int unsigned WW = fl4_pkg::WORD_W;

	// merge weights
	localparam fl4_pkg::sum_t K2  = fl4_pkg::SUM_W'(2);
	localparam fl4_pkg::sum_t K3  = fl4_pkg::SUM_W'(3);
	localparam fl4_pkg::sum_t K4  = fl4_pkg::SUM_W'(4);
	localparam fl4_pkg::sum_t K6  = fl4_pkg::SUM_W'(6);
	localparam fl4_pkg::sum_t K10 = fl4_pkg::SUM_W'(10);
	localparam fl4_pkg::sum_t K14 = fl4_pkg::SUM_W'(14);
	localparam fl4_pkg::sum_t K16 = fl4_pkg::SUM_W'(16);
	localparam fl4_pkg::sum_t K18 = fl4_pkg::SUM_W'(18);
	localparam fl4_pkg::sum_t K20 = fl4_pkg::SUM_W'(20);
	localparam fl4_pkg::sum_t K34 = fl4_pkg::SUM_W'(34);
	localparam fl4_pkg::sum_t K48 = fl4_pkg::SUM_W'(48);
	localparam fl4_pkg::sum_t K64 = fl4_pkg::SUM_W'(64);
	localparam fl4_pkg::sum_t K80 = fl4_pkg::SUM_W'(80);
	localparam fl4_pkg::sum_t K96 = fl4_pkg::SUM_W'(96);

	function automatic fl4_pkg::word_t swap32(input fl4_pkg::word_t w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// config register
	logic byte_swap_q;

	// stage 1: input register (words already swapped)
	logic           v_s1;
	fl4_pkg::word_t word_s1 [LN];
	logic           last_s1;

	// stage 2: snapshot of the lane sums after a tlast beat
	logic                v_s2;
	fl4_pkg::lane_sums_t snap_s2 [LN];

	// stage 3: merge partials
	logic          v_s3;
	fl4_pkg::sum_t sa_s3, sb_s3, sc_ab_s3, sc_c_s3, sd_ab_s3, sd_cd_s3;

	// output register
	logic          out_v_q;
	fl4_pkg::sum_t sa_q, sb_q, sc_q, sd_q;

	// flow control
	logic adv_out, adv_s3, adv_s2, take_s1;

	fl4_pkg::lane_sums_t lane_next [LN];
	fl4_pkg::lane_sums_t lane_cur  [LN];

	assign adv_out  = !out_v_q || m_tready;
	assign adv_s3   = !v_s3 || adv_out;
	assign adv_s2   = !v_s2 || adv_s3;
	// a plain beat always drains into the lanes; a tlast beat needs a free snapshot
	assign take_s1  = v_s1 && (!last_s1 || adv_s2);
	assign s_tready = !v_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_swap_q <= 1'b0;
		end else if (cfg_we) begin
			byte_swap_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			for (int i = 0; i < LN; i++) begin
				word_s1[i] <= byte_swap_q ? swap32(s_tdata[i*WW +: WW]) : s_tdata[i*WW +: WW];
			end
			last_s1 <= s_tlast;
		end
	end

	// lanes
	for (genvar g = 0; g < LN; g++) begin : g_lane
		fl4_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (take_s1),
			.clr       (last_s1),
			.word      (word_s1[g]),
			.sums_next (lane_next[g]),
			.sums      (lane_cur[g])
		);
	end

	// snapshot of the final lane sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= take_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && take_s1 && last_s1) begin
			snap_s2 <= lane_next;
		end
	end

	// merge, first half: grouped partial sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			sa_s3    <= snap_s2[0].a + snap_s2[1].a + snap_s2[2].a + snap_s2[3].a;
			sb_s3    <= K4 * (snap_s2[0].b + snap_s2[1].b + snap_s2[2].b + snap_s2[3].b)
			            - snap_s2[1].a - K2 * snap_s2[2].a - K3 * snap_s2[3].a;
			sc_ab_s3 <= snap_s2[2].a + K3 * snap_s2[3].a
			            - K6 * snap_s2[0].b - K10 * snap_s2[1].b
			            - K14 * snap_s2[2].b - K18 * snap_s2[3].b;
			sc_c_s3  <= K16 * (snap_s2[0].c + snap_s2[1].c + snap_s2[2].c + snap_s2[3].c);
			sd_ab_s3 <= K4 * snap_s2[0].b + K10 * snap_s2[1].b
			            + K20 * snap_s2[2].b + K34 * snap_s2[3].b - snap_s2[3].a;
			sd_cd_s3 <= K64 * (snap_s2[0].d + snap_s2[1].d + snap_s2[2].d + snap_s2[3].d)
			            - K48 * snap_s2[0].c - K64 * snap_s2[1].c
			            - K80 * snap_s2[2].c - K96 * snap_s2[3].c;
		end
	end

	// merge, second half into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s3) begin
			sa_q <= sa_s3;
			sb_q <= sb_s3;
			sc_q <= sc_ab_s3 + sc_c_s3;
			sd_q <= sd_ab_s3 + sd_cd_s3;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {sd_q, sc_q, sb_q, sa_q};

	// lanes start from zero after a tlast beat is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && last_s1 |=> lane_cur[0] == '0 && lane_cur[1] == '0
			&& lane_cur[2] == '0 && lane_cur[3] == '0)
		else $error("lanes not cleared after tlast beat");

	// input only stalls on a tlast beat blocked by a full merge pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && last_s1 && v_s2 && v_s3 && out_v_q && !m_tready)
		else $error("input stalled without a full merge pipe");

	// a blocked snapshot keeps its slot
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv_s2 |=> v_s2)
		else $error("snapshot lost while stalled");

endmodule

// ----- tb/fletcher4_four_lane_checksum_tb.sv -----
// Four-lane Fletcher-4 checksum testbench.
// Groups of four words are driven through the input stream from a queue.
// An in-bench lane model folds each accepted beat and, on a tlast beat,
// works out the merged checksum. Every output beat is then compared field by
// field with the oldest pending checksum. There are four phases, with
// byte_swap alternating off and on, each with a different mix of sender
// gaps and receiver stalls.
module fletcher4_four_lane_checksum_tb;

	localparam int RESET_CYCLES  = 8;
	// leave margin after the pipe drains, before a cfg write
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_BEATS  = 160;  // per phase
	localparam int LONG_FRAME    = 240;  // long enough for the merge terms to wrap
	localparam int PHASES        = 4;

	// one input beat; words[0] sits in the low bits of tdata
	typedef struct packed {
		logic                                     last;
		fl4_pkg::word_t [fl4_pkg::LANES-1:0]      words;
	} group_t;

	// one output beat; sum_a in the low bits of tdata
	typedef struct packed {
		fl4_pkg::sum_t d;
		fl4_pkg::sum_t c;
		fl4_pkg::sum_t b;
		fl4_pkg::sum_t a;
	} checksum_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic         cfg_wdata = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata   = '0;
	logic         s_tlast   = 1'b0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [255:0] m_tdata;

	fletcher4_four_lane_checksum u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// lane model
	logic          swap_bytes = 1'b0;
	fl4_pkg::sum_t lane_a[fl4_pkg::LANES];
	fl4_pkg::sum_t lane_b[fl4_pkg::LANES];
	fl4_pkg::sum_t lane_c[fl4_pkg::LANES];
	fl4_pkg::sum_t lane_d[fl4_pkg::LANES];

	group_t       pending_groups[$];
	checksum_t    expected_checksums[$];
	group_t       group_on_bus;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	int           mismatch_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic clear_lanes();
		for (int i = 0; i < fl4_pkg::LANES; i++) begin
			lane_a[i] = '0;
			lane_b[i] = '0;
			lane_c[i] = '0;
			lane_d[i] = '0;
		end
	endtask

	// fold one accepted beat into the lanes; a tlast beat yields the checksum
	task automatic fold_group(group_t g);
		checksum_t      cs;
		fl4_pkg::word_t w;
		for (int i = 0; i < fl4_pkg::LANES; i++) begin
			w = g.words[i];
			if (swap_bytes)
				w = {w[7:0], w[15:8], w[23:16], w[31:24]};
			lane_a[i] += fl4_pkg::sum_t'(w);
			lane_b[i] += lane_a[i];
			lane_c[i] += lane_b[i];
			lane_d[i] += lane_c[i];
		end
		if (g.last) begin
			// all terms unsigned 64-bit, so everything wraps mod 2^64
			cs.a = lane_a[0] + lane_a[1] + lane_a[2] + lane_a[3];
			cs.b = 4 * (lane_b[0] + lane_b[1] + lane_b[2] + lane_b[3])
				- lane_a[1] - 2 * lane_a[2] - 3 * lane_a[3];
			cs.c = lane_a[2] + 3 * lane_a[3]
				- 6 * lane_b[0] - 10 * lane_b[1] - 14 * lane_b[2] - 18 * lane_b[3]
				+ 16 * (lane_c[0] + lane_c[1] + lane_c[2] + lane_c[3]);
			cs.d = 64 * (lane_d[0] + lane_d[1] + lane_d[2] + lane_d[3])
				- lane_a[3]
				+ 4 * lane_b[0] + 10 * lane_b[1] + 20 * lane_b[2] + 34 * lane_b[3]
				- 48 * lane_c[0] - 64 * lane_c[1] - 80 * lane_c[2] - 96 * lane_c[3];
			expected_checksums.push_back(cs);
			clear_lanes();
		end
	endtask

	task automatic compare_field(string name, fl4_pkg::sum_t want, fl4_pkg::sum_t got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h got %h", $realtime, name, want, got);
		end
	endtask

	task automatic check_checksum(checksum_t got);
		checksum_t want;
		if (expected_checksums.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: output beat with nothing pending, a=%h b=%h c=%h d=%h",
					$realtime, got.a, got.b, got.c, got.d);
		end else begin
			want = expected_checksums.pop_front();
			compare_field("sum_a", want.a, got.a);
			compare_field("sum_b", want.b, got.b);
			compare_field("sum_c", want.c, got.c);
			compare_field("sum_d", want.d, got.d);
		end
	endtask

	// driver: fold the beat taken at this edge, then offer the next or idle
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			fold_group(group_on_bus);
		if (!s_tvalid || s_tready) begin
			if (pending_groups.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				group_on_bus = pending_groups.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= group_on_bus.words;
				s_tlast  <= group_on_bus.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: check each output beat, stall at random
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_checksum(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void push_group(fl4_pkg::word_t w0, fl4_pkg::word_t w1,
			fl4_pkg::word_t w2, fl4_pkg::word_t w3, logic last);
		group_t g;
		g.words[0] = w0;
		g.words[1] = w1;
		g.words[2] = w2;
		g.words[3] = w3;
		g.last     = last;
		pending_groups.push_back(g);
	endfunction

	// mostly random, with a share of zeros, all ones and single bits
	function automatic fl4_pkg::word_t pick_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return fl4_pkg::word_t'(1) << $urandom_range(fl4_pkg::WORD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// frames mostly short, now and then a longer one
	task automatic load_random_frames(int count);
		int len;
		while (count > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int i = 1; i <= len; i++)
				push_group(pick_word(), pick_word(), pick_word(), pick_word(), i == len);
			count -= len;
		end
	endtask

	task automatic load_directed();
		// single-beat frame straight after a clear, zero and full scale
		push_group('0, '0, '0, '0, 1'b1);
		push_group('1, '1, '1, '1, 1'b1);
		// all ones over a short frame
		for (int i = 0; i < 5; i++)
			push_group('1, '1, '1, '1, i == 4);
		// one live lane at a time shows the per-lane weights
		push_group(32'h0000_0001, '0, '0, '0, 1'b1);
		push_group('0, 32'h0000_0001, '0, '0, 1'b1);
		push_group('0, '0, 32'h0000_0001, '0, 1'b1);
		push_group('0, '0, '0, 32'h0000_0001, 1'b1);
		// top and bottom bits, distinct bytes
		push_group(32'h8000_0000, 32'h0000_0001, 32'h8000_0001, 32'h7fff_fffe, 1'b0);
		push_group(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210, 1'b1);
		push_group(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000, 32'h0000_ffff, 1'b1);
	endtask

	task automatic load_swap_directed();
		// asymmetric bytes so a wrong swap cannot hide
		push_group(32'h1122_3344, 32'h0000_00ff, 32'hff00_0000, 32'h00ff_0000, 1'b1);
		push_group(32'h0102_0304, 32'h8000_0000, 32'h0000_0080, 32'hdead_beef, 1'b0);
		push_group(32'hcafe_f00d, 32'h0000_0001, 32'h0100_0000, 32'h1234_5678, 1'b1);
	endtask

	task automatic write_swap(logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		swap_bytes = v;
	endtask

	task automatic wait_drained();
		while (pending_groups.size() != 0 || s_tvalid || expected_checksums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clear_lanes();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			// phase 0 free flowing, then sender gaps, receiver stalls, both
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			// swap off, on, off, on; lanes idle here
			write_swap(1'(phase % 2));
			@(negedge clk);
			if (phase == 0)
				load_directed();
			if (phase == 1)
				load_swap_directed();
			if (phase == 3) begin
				for (int i = 1; i <= LONG_FRAME; i++)
					push_group('1, '1, '1, '1, i == LONG_FRAME);
			end
			load_random_frames(RANDOM_BEATS);
			wait_drained();
		end

		if (mismatch_count == 0 && expected_checksums.size() == 0) begin
			$display("PASS fletcher4_four_lane_checksum");
		end else begin
			$display("FAIL fletcher4_four_lane_checksum");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL fletcher4_four_lane_checksum");
		$finish;
	end

endmodule
